[hdl/bpcd_pkg.sv]
// ----------------------------------------------------------------------------
// bpcd_pkg
// Types, codes and sizes shared by the pair-code dictionary modules.
// ----------------------------------------------------------------------------
package bpcd_pkg;

    localparam int ENTRIES_DEFAULT = 256;
    localparam int KEY_W = 17;
    localparam int BYTE_W = 8;
    localparam logic [BYTE_W-1:0] CODE_START = 8'd255;

    localparam logic [1:0] MODE_LEARN  = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_ENCODE = 2'd2;
    localparam logic [1:0] MODE_DECODE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [BYTE_W-1:0] code;
    } entry_t;

    // Lookup token that travels down the row of cells.
    typedef struct packed {
        logic              active;
        logic              by_code;
        logic [KEY_W-1:0]  key;
        logic [BYTE_W-1:0] code;
        logic              found;
        logic [KEY_W-1:0]  hit_key;
        logic [BYTE_W-1:0] hit_code;
    } query_t;

endpackage

[hdl/bpcd_cell.sv]
// ----------------------------------------------------------------------------
// bpcd_cell
// One dictionary slot: holds an entry, shifts it on insert, and compares the
// passing lookup token against it.
// ----------------------------------------------------------------------------
module bpcd_cell
    import bpcd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   live,
    input  logic   shift_en,
    input  entry_t entry_in,
    output entry_t entry_out,
    input  query_t q_in,
    output query_t q_out
);

    entry_t entry_reg;
    query_t q_reg;
    query_t q_next;
    logic   match;

    assign match = q_in.by_code ? (entry_reg.code == q_in.code) : (entry_reg.key == q_in.key);

    // The first live match seen is the most recent entry, since new entries
    // enter at the head of the row.
    always_comb begin
        q_next = q_in;
        if (q_in.active && live && !q_in.found && match) begin
            q_next.found    = 1'b1;
            q_next.hit_key  = entry_reg.key;
            q_next.hit_code = entry_reg.code;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= entry_in;
        end
        if (!aresetn) begin
            q_reg <= '0;
        end else begin
            q_reg <= q_next;
        end
    end

    assign entry_out = entry_reg;
    assign q_out     = q_reg;

endmodule

[hdl/byte_pair_code_dictionary_core.sv]
// ----------------------------------------------------------------------------
// byte_pair_code_dictionary_core
// Pair-code dictionary built as a row of ENTRIES cells.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A learn, encode or decode lookup
// sends a token down the row of cells, one cell per cycle; its result is
// registered in RUN and then put out from DONE. A load skips the row and goes
// straight to DONE. An insert shifts the whole row by one cell, newest entry at
// the head. A new transaction is accepted while the previous result waits.
module byte_pair_code_dictionary_core
    import bpcd_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_first_char,
    input  logic [7:0]  s_second_char,
    input  logic        s_single,
    input  logic [7:0]  s_code_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_code_out,
    output logic [7:0]  m_first_out,
    output logic [7:0]  m_second_out,
    output logic        m_single_out,
    output logic [1:0]  m_status
);

    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [BYTE_W-1:0]  next_code_reg;
    logic [1:0]         mode_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [BYTE_W-1:0]  code_in_reg;
    logic               found_reg;
    logic [KEY_W-1:0]   hit_key_reg;
    logic [BYTE_W-1:0]  hit_code_reg;

    logic               m_valid_reg;
    logic [7:0]         code_out_reg, first_out_reg, second_out_reg;
    logic               single_out_reg;
    logic [1:0]         status_reg;

    logic               accept;
    logic               finish;
    logic               full;
    logic               do_insert;
    logic [KEY_W-1:0]   s_key;
    logic [BYTE_W-1:0]  code_out_next, first_out_next, second_out_next;
    logic               single_out_next;
    logic [1:0]         status_next;
    entry_t             head_entry;

    entry_t entry_chain [ENTRIES+1];
    query_t q_chain     [ENTRIES+1];

    assign s_ready = (state_reg == IDLE);
    assign accept  = s_valid && s_ready;
    assign finish  = (state_reg == DONE) && (!m_valid_reg || m_ready);
    assign full    = (count_reg == CNT_W'(ENTRIES));
    assign s_key   = {s_single, s_first_char, s_single ? 8'd0 : s_second_char};

    always_comb begin
        q_chain[0]         = '0;
        q_chain[0].active  = accept && (s_mode != MODE_LOAD);
        q_chain[0].by_code = (s_mode == MODE_DECODE);
        q_chain[0].key     = s_key;
        q_chain[0].code    = s_code_in;
    end

    assign head_entry.key  = key_reg;
    assign head_entry.code = (mode_reg == MODE_LOAD) ? code_in_reg : next_code_reg;
    assign entry_chain[0]  = head_entry;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            bpcd_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .live      (CNT_W'(gi) < count_reg),
                .shift_en  (do_insert),
                .entry_in  (entry_chain[gi]),
                .entry_out (entry_chain[gi+1]),
                .q_in      (q_chain[gi]),
                .q_out     (q_chain[gi+1])
            );
        end
    endgenerate

    always_comb begin
        code_out_next   = '0;
        first_out_next  = '0;
        second_out_next = '0;
        single_out_next = 1'b0;
        status_next     = ST_OK;
        do_insert       = 1'b0;
        case (mode_reg)
            MODE_LEARN: begin
                if (found_reg) begin
                    code_out_next = hit_code_reg;
                    status_next   = ST_PRESENT;
                end else begin
                    code_out_next = next_code_reg;
                    status_next   = full ? ST_FULL : ST_OK;
                    do_insert     = finish && !full;
                end
            end
            MODE_LOAD: begin
                code_out_next = code_in_reg;
                status_next   = full ? ST_FULL : ST_OK;
                do_insert     = finish && !full;
            end
            MODE_ENCODE: begin
                if (found_reg) begin
                    code_out_next = hit_code_reg;
                end else begin
                    status_next = ST_MISSING;
                end
            end
            default: begin
                code_out_next = code_in_reg;
                if (found_reg) begin
                    single_out_next = hit_key_reg[16];
                    first_out_next  = hit_key_reg[15:8];
                    second_out_next = hit_key_reg[7:0];
                end else begin
                    status_next = ST_MISSING;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            next_code_reg <= CODE_START;
            m_valid_reg   <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !finish) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (accept) begin
                        mode_reg    <= s_mode;
                        key_reg     <= s_key;
                        code_in_reg <= s_code_in;
                        found_reg   <= 1'b0;
                        state_reg   <= (s_mode == MODE_LOAD) ? DONE : RUN;
                    end
                end
                RUN: begin
                    if (q_chain[ENTRIES].active) begin
                        found_reg    <= q_chain[ENTRIES].found;
                        hit_key_reg  <= q_chain[ENTRIES].hit_key;
                        hit_code_reg <= q_chain[ENTRIES].hit_code;
                        state_reg    <= DONE;
                    end
                end
                DONE: begin
                    if (finish) begin
                        m_valid_reg    <= 1'b1;
                        code_out_reg   <= code_out_next;
                        first_out_reg  <= first_out_next;
                        second_out_reg <= second_out_next;
                        single_out_reg <= single_out_next;
                        status_reg     <= status_next;
                        if (do_insert) begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (mode_reg == MODE_LEARN) begin
                            next_code_reg <= next_code_reg - 1'b1;
                        end
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_code_out   = code_out_reg;
    assign m_first_out  = first_out_reg;
    assign m_second_out = second_out_reg;
    assign m_single_out = single_out_reg;
    assign m_status     = status_reg;

endmodule

[hdl/bpcd_checker.sv]
// ----------------------------------------------------------------------------
// bpcd_checker
// Port-level checks for the pair-code dictionary, bound to the top level.
// ----------------------------------------------------------------------------
module bpcd_checker
    import bpcd_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_code_out,
    input logic [7:0] m_first_out,
    input logic [7:0] m_second_out,
    input logic       m_single_out,
    input logic [1:0] m_status
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_out) && $stable(m_status))
        else $error("result changed while stalled");

    // Only a decode hit returns a key.
    a_no_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> m_first_out == 8'd0 && m_second_out == 8'd0
            && !m_single_out)
        else $error("key bytes on a result without a decode hit");

    // A lone byte is stored with a zero second byte.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_single_out |-> m_second_out == 8'd0)
        else $error("single key with nonzero second byte");

    // An accepted transaction yields no result in the very next cycle.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result appeared too early");

endmodule

bind byte_pair_code_dictionary_core bpcd_checker u_bpcd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_code_out   (m_code_out),
    .m_first_out  (m_first_out),
    .m_second_out (m_second_out),
    .m_single_out (m_single_out),
    .m_status     (m_status)
);
